### design/ftrsm_pkg.sv
// Shared constants, types and register codes of the fan tacho monitor.
`default_nettype none
package ftrsm_pkg;

    localparam int NUM_FANS    = 6;
    localparam int TACHO_LINES = 6;
    localparam int FAN_CNT_W   = (NUM_FANS > 1) ? $clog2(NUM_FANS) : 1;

    localparam int LEVELS_W    = 6;
    localparam int COUNT_W     = 8;
    localparam int BYTE_W      = 8;
    localparam int TABLE_W     = 48;
    localparam int FAN_IDX_W   = 3;
    localparam int RPS_W       = 16;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 24;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RISE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_MASK  = 2'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_REPORT = 2'b10
    } state_t;

    typedef struct packed {
        logic sample;
        logic tick_start;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic fan_last;
    } dp_stat_t;

endpackage
`default_nettype wire

### design/ftrsm_ctrl.sv
// Controller: input handshake, fan sweep sequencing and result valid.
`default_nettype none
module ftrsm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic              s_kind,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output ftrsm_pkg::dp_cmd_t     cmd,
    input  wire ftrsm_pkg::dp_stat_t stat,
    output ftrsm_pkg::state_t      state
);
    import ftrsm_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept;
    logic   emit;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign emit     = (state_reg == ST_REPORT) && (!m_tvalid_reg || m_tready);

    assign cmd.sample     = accept && (s_kind == KIND_SAMPLE);
    assign cmd.tick_start = accept && (s_kind == KIND_TICK);
    assign cmd.emit       = emit;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_kind == KIND_TICK)) begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (emit && stat.fan_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign state    = state_reg;

endmodule
`default_nettype wire

### design/ftrsm_datapath.sv
// Datapath: config registers, edge counters, rps multiply and result register.
`default_nettype none
module ftrsm_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    input  wire logic [ftrsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ftrsm_pkg::TABLE_W-1:0]     cfg_data,
    input  wire logic [ftrsm_pkg::LEVELS_W-1:0]    levels,
    input  wire ftrsm_pkg::dp_cmd_t                cmd,
    output ftrsm_pkg::dp_stat_t                    stat,
    output logic [ftrsm_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                   m_tlast
);
    import ftrsm_pkg::*;

    logic [TABLE_W-1:0]   step_tbl_reg;
    logic [TABLE_W-1:0]   thr_tbl_reg;
    logic [LEVELS_W-1:0]  mask_reg;
    logic [LEVELS_W-1:0]  prev_levels_reg;
    logic [COUNT_W-1:0]   count_reg [NUM_FANS];
    logic [FAN_CNT_W-1:0] fan_idx_reg;
    logic [LEVELS_W-1:0]  rises;

    logic [BYTE_W-1:0]    step_sel;
    logic [BYTE_W-1:0]    thr_sel;
    logic                 has_tacho;
    logic [RPS_W-1:0]     product;
    logic [RPS_W-1:0]     rps;
    logic                 stalled;
    logic                 fan_last;

    logic [FAN_IDX_W-1:0] out_idx_reg;
    logic [RPS_W-1:0]     out_rps_reg;
    logic                 out_stalled_reg;
    logic                 out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_tbl_reg <= '0;
            thr_tbl_reg  <= '0;
            mask_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RISE_STEP: step_tbl_reg <= cfg_data;
                REG_STALL_THR: thr_tbl_reg  <= cfg_data;
                REG_FAN_MASK:  mask_reg     <= cfg_data[LEVELS_W-1:0];
                default: ;
            endcase
        end
    end

    assign rises    = levels & ~prev_levels_reg;
    assign fan_last = (fan_idx_reg == FAN_CNT_W'(NUM_FANS - 1));
    assign stat.fan_last = fan_last;

    always_comb begin
        step_sel  = '0;
        thr_sel   = '0;
        has_tacho = 1'b0;
        for (int j = 0; j < TACHO_LINES; j++) begin
            if (32'(fan_idx_reg) == j) begin
                step_sel  = step_tbl_reg[BYTE_W*j +: BYTE_W];
                thr_sel   = thr_tbl_reg[BYTE_W*j +: BYTE_W];
                has_tacho = mask_reg[j];
            end
        end
    end

    assign product = RPS_W'(count_reg[fan_idx_reg]) * RPS_W'(step_sel);
    assign rps     = has_tacho ? product : '0;
    assign stalled = has_tacho && (thr_sel != '0) && (product[RPS_W-1:BYTE_W] < thr_sel);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_levels_reg <= '0;
            fan_idx_reg     <= '0;
            for (int i = 0; i < NUM_FANS; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            if (cmd.sample) begin
                prev_levels_reg <= levels;
                for (int i = 0; i < NUM_FANS; i++) begin
                    if (i < TACHO_LINES && rises[i % LEVELS_W]) begin
                        count_reg[i] <= count_reg[i] + COUNT_W'(1);
                    end
                end
            end
            if (cmd.tick_start) begin
                fan_idx_reg <= '0;
            end else if (cmd.emit) begin
                count_reg[fan_idx_reg] <= '0;
                fan_idx_reg <= fan_last ? '0 : fan_idx_reg + FAN_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_idx_reg     <= FAN_IDX_W'(fan_idx_reg);
            out_rps_reg     <= rps;
            out_stalled_reg <= stalled;
            out_last_reg    <= fan_last;
        end
    end

    assign m_tdata = {{(OUT_DATA_W - FAN_IDX_W - RPS_W - 1){1'b0}},
                      out_stalled_reg, out_rps_reg, out_idx_reg};
    assign m_tlast = out_last_reg;

endmodule
`default_nettype wire

### design/fan_tacho_rps_stall_monitor.sv
// Six fan tacho monitor: counts rising edges per fan and reports rps and stall on each
// tick. A sample beat leaves the block idle, so it is ready again on the next cycle.
// A tick beat starts a sweep that produces one result beat per fan, fan 0 first, one
// per cycle while the master side is ready; the sweep shares a single 8x8 multiplier
// and the input side is held off until the last fan's result is in the output register.
`default_nettype none
module fan_tacho_rps_stall_monitor (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [5:0] tacho_levels, [7:6] zero
    input  wire logic        s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [2:0] fan_index, [18:3] fan_rps, [19] fan_stalled
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);
    import ftrsm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    state_t   state;

    assign cfg_ready = 1'b1;

    ftrsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat),
        .state    (state)
    );

    ftrsm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .levels    (s_tdata[LEVELS_W-1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_no_input_during_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ST_REPORT) |-> !s_tready)
        else $error("input accepted during fan sweep");

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

    a_last_on_final_fan: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[2:0] == 3'(NUM_FANS - 1)))
        else $error("last flag on wrong fan");

    a_fan_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= 3'(NUM_FANS - 1)))
        else $error("fan index out of range");

endmodule
`default_nettype wire
